FILE: design/lpu_pkg.sv
// Shared types and constants of the LCD pixel unpacker with colour lookup table.
package lpu_pkg;

  // Default colour table depth
  localparam int TABLE_ENTRIES_DEF = 256;

  // Configuration register indexes
  localparam logic [1:0] CFG_WIDTH_GROUPS  = 2'd0;
  localparam logic [1:0] CFG_SCREEN_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_DEPTH_SELECT  = 2'd2;

  // Depth select codes
  localparam logic [2:0] DEPTH_1BPP  = 3'd0;
  localparam logic [2:0] DEPTH_2BPP  = 3'd1;
  localparam logic [2:0] DEPTH_4BPP  = 3'd2;
  localparam logic [2:0] DEPTH_8BPP  = 3'd3;
  localparam logic [2:0] DEPTH_16BPP = 3'd4;

  // Input command codes
  localparam logic CMD_PIXEL_BYTE = 1'b0;
  localparam logic CMD_TABLE_WR   = 1'b1;

  typedef struct packed {
    logic [6:0] width_groups;
    logic [8:0] screen_height;
    logic [2:0] depth_select;
  } cfg_t;

  // One pixel issued toward the output stage
  typedef struct packed {
    logic        issue;
    logic        direct;        // 16 bpp: colour taken from rgb565
    logic [7:0]  index;         // colour table index otherwise
    logic [15:0] rgb565;
    logic        last_of_byte;
  } pix_req_t;

  // Colour table write
  typedef struct packed {
    logic        en;
    logic [7:0]  index;
    logic [11:0] colour;
  } tbl_wr_t;

endpackage

FILE: design/lpu_clut.sv
// Colour lookup table: single-port write, registered read, per-entry valid bits.
module lpu_clut #(
  parameter int TABLE_ENTRIES = lpu_pkg::TABLE_ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  lpu_pkg::tbl_wr_t   wr,
  input  logic               rd_en,
  input  logic [7:0]         rd_index,
  output logic [11:0]        rd_colour
);

  localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  logic [11:0]              mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] valid_r;
  logic [11:0]              rd_data_r;
  logic                     rd_hit_r;
  logic                     wr_in_range;
  logic                     rd_in_range;
  logic [AW-1:0]            wr_addr;
  logic [AW-1:0]            rd_addr;

  assign wr_in_range = {1'b0, wr.index} < 9'(TABLE_ENTRIES);
  assign rd_in_range = {1'b0, rd_index} < 9'(TABLE_ENTRIES);
  assign wr_addr     = wr.index[AW-1:0];
  assign rd_addr     = rd_index[AW-1:0];

  // Write and read the storage array
  always_ff @(posedge clk) begin
    if (wr.en && wr_in_range) begin
      mem[wr_addr] <= wr.colour;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Mark entries written since reset; hold the hit flag with the read data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_hit_r <= 1'b0;
    end else begin
      if (wr.en && wr_in_range) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_hit_r <= rd_in_range && valid_r[rd_addr];
      end
    end
  end

  // Unwritten or out-of-range entries read as black
  assign rd_colour = rd_hit_r ? rd_data_r : 12'h000;

endmodule

FILE: design/lpu_unpack.sv
// Input register and byte unpacker: issues one pixel per cycle from the held byte while the output can advance.
module lpu_unpack (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_cmd,
  input  logic [7:0]         in_pixel_byte,
  input  logic [7:0]         in_table_index,
  input  logic [11:0]        in_table_colour,
  input  lpu_pkg::cfg_t      cfg,
  input  logic               adv_ok,
  output lpu_pkg::pix_req_t  req,
  output lpu_pkg::tbl_wr_t   tbl_wr
);

  logic        item_valid_r, item_valid_nxt;
  logic        cmd_r;
  logic [7:0]  byte_r;
  logic [7:0]  tidx_r;
  logic [11:0] tcol_r;
  logic [2:0]  pos_r, pos_nxt;
  logic [7:0]  held_r, held_nxt;
  logic        hv_r, hv_nxt;

  logic        cfg_ok;
  logic        is_pix;
  logic        is_16;
  logic        want;
  logic        issue;
  logic        last;
  logic        done;
  logic        accept;
  logic [2:0]  last_pos;
  logic [5:0]  shamt;
  logic [7:0]  shifted;
  logic [7:0]  index;

  assign cfg_ok = (cfg.width_groups != 7'd0) && (cfg.screen_height != 9'd0) &&
                  (cfg.depth_select <= lpu_pkg::DEPTH_16BPP);
  assign is_pix = item_valid_r && (cmd_r == lpu_pkg::CMD_PIXEL_BYTE);
  assign is_16  = (cfg.depth_select == lpu_pkg::DEPTH_16BPP);
  assign want   = is_pix && cfg_ok && (!is_16 || hv_r);
  assign issue  = want && adv_ok;

  // Last pixel position within a byte for the current depth
  assign last_pos = 3'(3'd7 >> cfg.depth_select[1:0]);
  assign last     = is_16 || (pos_r == last_pos);

  assign done     = item_valid_r && (!want || (adv_ok && last));
  assign in_stall = item_valid_r && !done;
  assign accept   = in_valid && !in_stall;

  // Select the pixel field, most significant first
  assign shamt   = 6'(pos_r) << cfg.depth_select[1:0];
  assign shifted = byte_r << shamt[2:0];

  always_comb begin
    case (cfg.depth_select)
      lpu_pkg::DEPTH_1BPP: index = {7'd0, shifted[7]};
      lpu_pkg::DEPTH_2BPP: index = {6'd0, shifted[7:6]};
      lpu_pkg::DEPTH_4BPP: index = {4'd0, shifted[7:4]};
      lpu_pkg::DEPTH_8BPP: index = shifted;
      default:             index = 8'd0;
    endcase
  end

  // Drive the pixel request and the table write
  always_comb begin
    req.issue        = issue;
    req.direct       = is_16;
    req.index        = index;
    req.rgb565       = {held_r, byte_r};
    req.last_of_byte = last;
    tbl_wr.en        = item_valid_r && (cmd_r == lpu_pkg::CMD_TABLE_WR);
    tbl_wr.index     = tidx_r;
    tbl_wr.colour    = tcol_r;
  end

  // Next state of the item slot, position and 16 bpp pairing
  always_comb begin
    item_valid_nxt = item_valid_r;
    pos_nxt        = pos_r;
    held_nxt       = held_r;
    hv_nxt         = hv_r;
    if (done) begin
      item_valid_nxt = 1'b0;
      pos_nxt        = 3'd0;
    end else if (issue) begin
      pos_nxt = pos_r + 3'd1;
    end
    if (accept) begin
      item_valid_nxt = 1'b1;
    end
    if (done && is_pix) begin
      if (cfg_ok && is_16 && !hv_r) begin
        held_nxt = byte_r;
        hv_nxt   = 1'b1;
      end else begin
        hv_nxt = 1'b0;
      end
    end
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      pos_r        <= 3'd0;
      held_r       <= 8'd0;
      hv_r         <= 1'b0;
    end else begin
      item_valid_r <= item_valid_nxt;
      pos_r        <= pos_nxt;
      held_r       <= held_nxt;
      hv_r         <= hv_nxt;
    end
  end

  // Capture the accepted transaction
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r  <= in_cmd;
      byte_r <= in_pixel_byte;
      tidx_r <= in_table_index;
      tcol_r <= in_table_colour;
    end
  end

endmodule

FILE: design/lpu_scan.sv
// Column and row counters that flag the last pixel of each line and frame.
module lpu_scan (
  input  logic           clk,
  input  logic           rst_n,
  input  lpu_pkg::cfg_t  cfg,
  input  logic           issue,
  output logic           eol,
  output logic           eof
);

  logic [9:0]  col_r, col_nxt;
  logic [8:0]  row_r, row_nxt;
  logic [10:0] col_inc;
  logic [9:0]  row_inc;
  logic [9:0]  width;

  assign width   = {cfg.width_groups, 3'b000};
  assign col_inc = 11'(col_r) + 11'd1;
  assign row_inc = 10'(row_r) + 10'd1;
  assign eol     = col_inc >= {1'b0, width};
  assign eof     = eol && (row_inc >= {1'b0, cfg.screen_height});

  // Advance counters on each issued pixel
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (issue) begin
      if (eol) begin
        col_nxt = 10'd0;
        row_nxt = eof ? 9'd0 : row_inc[8:0];
      end else begin
        col_nxt = col_inc[9:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= 10'd0;
      row_r <= 9'd0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

FILE: design/lcd_pixel_unpack_clut_unit.sv
// Top level of the LCD pixel unpacker: configuration, output register, colour widening.
//
//  Channel | Handshake              | Payload
//  --------+------------------------+---------------------------------------------------
//  in      | in_valid / in_stall    | in_cmd, in_pixel_byte, in_table_index,
//          |                        | in_table_colour
//  out     | out_valid / out_stall  | out_red, out_green, out_blue, out_end_of_byte,
//          |                        | out_end_of_line, out_end_of_frame
//  cfg     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// A byte at 1/2/4/8 bpp occupies the input register until its 8/4/2/1 pixels are issued,
// one pixel per cycle while out_stall allows; the colour table read port sets this pace.
// Table writes, invalid bytes and the first byte of a 16 bpp pair leave without a pixel.
// A pixel appears at the output in the cycle after it is issued (registered table read).
// Reset is synchronous; the table reads as black until each entry is written.
// out_stall holds the output register and backs up into in_stall in the same cycle.
module lcd_pixel_unpack_clut_unit #(
  parameter int TABLE_ENTRIES = lpu_pkg::TABLE_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_cmd,
  input  logic [7:0]  in_pixel_byte,
  input  logic [7:0]  in_table_index,
  input  logic [11:0] in_table_colour,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic        out_end_of_byte,
  output logic        out_end_of_line,
  output logic        out_end_of_frame,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data
);

  lpu_pkg::cfg_t     cfg_r;
  lpu_pkg::pix_req_t req;
  lpu_pkg::tbl_wr_t  tbl_wr;

  logic        adv_ok;
  logic        eol, eof;
  logic [11:0] lut_colour;
  logic        out_valid_r, out_valid_nxt;
  logic        direct_r;
  logic [15:0] rgb565_r;
  logic        eob_r, eol_r, eof_r;

  assign cfg_ready = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lpu_pkg::CFG_WIDTH_GROUPS:  cfg_r.width_groups  <= cfg_data[6:0];
        lpu_pkg::CFG_SCREEN_HEIGHT: cfg_r.screen_height <= cfg_data;
        lpu_pkg::CFG_DEPTH_SELECT:  cfg_r.depth_select  <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // Output register may load when empty or draining
  assign adv_ok = !out_valid_r || !out_stall;

  lpu_unpack u_unpack (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cmd          (in_cmd),
    .in_pixel_byte   (in_pixel_byte),
    .in_table_index  (in_table_index),
    .in_table_colour (in_table_colour),
    .cfg             (cfg_r),
    .adv_ok          (adv_ok),
    .req             (req),
    .tbl_wr          (tbl_wr)
  );

  lpu_clut #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_clut (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr        (tbl_wr),
    .rd_en     (req.issue),
    .rd_index  (req.index),
    .rd_colour (lut_colour)
  );

  lpu_scan u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_r),
    .issue (req.issue),
    .eol   (eol),
    .eof   (eof)
  );

  // Output valid: set on issue, drop when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (req.issue) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Capture pixel side data alongside the table read
  always_ff @(posedge clk) begin
    if (req.issue) begin
      direct_r <= req.direct;
      rgb565_r <= req.rgb565;
      eob_r    <= req.last_of_byte;
      eol_r    <= eol;
      eof_r    <= eof;
    end
  end

  // Widen channels: nibble replication for table colours, zero fill for RGB565
  always_comb begin
    if (direct_r) begin
      out_red   = {rgb565_r[15:11], 3'b000};
      out_green = {rgb565_r[10:5], 2'b00};
      out_blue  = {rgb565_r[4:0], 3'b000};
    end else begin
      out_red   = {lut_colour[11:8], lut_colour[11:8]};
      out_green = {lut_colour[7:4], lut_colour[7:4]};
      out_blue  = {lut_colour[3:0], lut_colour[3:0]};
    end
  end

  assign out_valid        = out_valid_r;
  assign out_end_of_byte  = eob_r;
  assign out_end_of_line  = eol_r;
  assign out_end_of_frame = eof_r;

endmodule

FILE: tb/lcd_pixel_unpack_clut_unit_checker.sv
// Scoreboard for the LCD pixel unpacker: predicts pixels from accepted transactions and compares.
module lcd_pixel_unpack_clut_unit_checker #(
  parameter int TABLE_ENTRIES = lpu_pkg::TABLE_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_cmd,
  input  logic [7:0]  in_pixel_byte,
  input  logic [7:0]  in_table_index,
  input  logic [11:0] in_table_colour,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  out_red,
  input  logic [7:0]  out_green,
  input  logic [7:0]  out_blue,
  input  logic        out_end_of_byte,
  input  logic        out_end_of_line,
  input  logic        out_end_of_frame,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data,
  output int          mismatch_count,
  output int          pending_pixels,
  output int          pixels_checked,
  output int          frames_closed
);

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       end_of_byte;
    logic       end_of_line;
    logic       end_of_frame;
  } pixel_t;

  // Shadow copy of the block's state and registers
  logic [11:0]    colour_lut [TABLE_ENTRIES];
  logic [9:0]     column_q;
  logic [8:0]     row_q;
  logic [7:0]     high_byte_q;
  logic           high_byte_held;
  lpu_pkg::cfg_t  cfg_q;
  pixel_t         expected_pixels [$];

  // Widen a 4-bit channel by nibble replication
  function automatic logic [7:0] widen(input logic [3:0] c);
    return {c, c};
  endfunction

  // Queue one pixel and advance the raster position
  function automatic void emit_pixel(input logic [7:0] r, input logic [7:0] g,
                                     input logic [7:0] b, input logic last_of_byte);
    pixel_t p;
    int     line_len;
    line_len = int'(cfg_q.width_groups) * 8;
    p.red = r;
    p.green = g;
    p.blue = b;
    p.end_of_byte = last_of_byte;
    p.end_of_line = (int'(column_q) + 1 >= line_len);
    p.end_of_frame = 1'b0;
    if (p.end_of_line) begin
      column_q = '0;
      p.end_of_frame = (int'(row_q) + 1 >= int'(cfg_q.screen_height));
      row_q = p.end_of_frame ? 9'd0 : row_q + 9'd1;
    end else begin
      column_q = column_q + 10'd1;
    end
    expected_pixels.push_back(p);
  endfunction

  // Work out the pixels that one accepted input transaction causes
  function automatic void predict_pixels(input logic cmd, input logic [7:0] pbyte,
                                         input logic [7:0] idx, input logic [11:0] colour);
    logic [2:0]  depth;
    logic [15:0] rgb;
    logic [7:0]  lut_idx;
    logic [11:0] c;
    int          bpp;
    int          per_byte;
    int          shift;
    depth = cfg_q.depth_select;
    if (cmd == lpu_pkg::CMD_TABLE_WR) begin
      if (int'(idx) < TABLE_ENTRIES) colour_lut[idx] = colour;
    end else if (cfg_q.width_groups == '0 || cfg_q.screen_height == '0 ||
                 depth > lpu_pkg::DEPTH_16BPP) begin
      high_byte_held = 1'b0;
    end else if (depth == lpu_pkg::DEPTH_16BPP) begin
      if (!high_byte_held) begin
        high_byte_q = pbyte;
        high_byte_held = 1'b1;
      end else begin
        high_byte_held = 1'b0;
        rgb = {high_byte_q, pbyte};
        emit_pixel({rgb[15:11], 3'b000}, {rgb[10:5], 2'b00}, {rgb[4:0], 3'b000}, 1'b1);
      end
    end else begin
      high_byte_held = 1'b0;
      bpp = 1 << depth;
      per_byte = 8 / bpp;
      for (int k = 0; k < per_byte; k++) begin
        shift = 8 - bpp * (k + 1);
        lut_idx = (pbyte >> shift) & 8'((1 << bpp) - 1);
        c = (int'(lut_idx) < TABLE_ENTRIES) ? colour_lut[lut_idx] : 12'h000;
        emit_pixel(widen(c[11:8]), widen(c[7:4]), widen(c[3:0]), k == per_byte - 1);
      end
    end
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  // Track register writes, check results, then predict from the input transaction
  always @(posedge clk) begin : monitor
    pixel_t want;
    if (!rst_n) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) colour_lut[i] = '0;
      column_q = '0;
      row_q = '0;
      high_byte_q = '0;
      high_byte_held = 1'b0;
      cfg_q = '0;
      expected_pixels.delete();
      mismatch_count = 0;
      pixels_checked = 0;
      frames_closed = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          lpu_pkg::CFG_WIDTH_GROUPS:  cfg_q.width_groups = cfg_data[6:0];
          lpu_pkg::CFG_SCREEN_HEIGHT: cfg_q.screen_height = cfg_data[8:0];
          lpu_pkg::CFG_DEPTH_SELECT:  cfg_q.depth_select = cfg_data[2:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_pixels.size() == 0) begin
          $error("pixel transaction with no expected pixel pending");
          mismatch_count++;
        end else begin
          want = expected_pixels.pop_front();
          check_field("red", want.red, out_red);
          check_field("green", want.green, out_green);
          check_field("blue", want.blue, out_blue);
          check_field("end_of_byte", want.end_of_byte, out_end_of_byte);
          check_field("end_of_line", want.end_of_line, out_end_of_line);
          check_field("end_of_frame", want.end_of_frame, out_end_of_frame);
          pixels_checked++;
          if (want.end_of_frame) frames_closed++;
        end
      end
      if (in_valid && !in_stall) begin
        predict_pixels(in_cmd, in_pixel_byte, in_table_index, in_table_colour);
      end
    end
    pending_pixels = expected_pixels.size();
  end

endmodule

FILE: tb/lcd_pixel_unpack_clut_unit_tb.sv
// Testbench top for the LCD pixel unpacker: clock, reset, stimulus, back-pressure and verdict.
module lcd_pixel_unpack_clut_unit_tb;

  localparam int         CYCLE_LIMIT   = 400000;
  localparam int         RANDOM_ITEMS  = 460;
  localparam int         SETTLE_CYCLES = 12;
  localparam logic [1:0] CFG_SPARE     = 2'd3;
  localparam logic [2:0] DEPTH_BAD     = 3'd7;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_cmd;
  logic [7:0]  in_pixel_byte;
  logic [7:0]  in_table_index;
  logic [11:0] in_table_colour;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;
  logic        out_end_of_byte;
  logic        out_end_of_line;
  logic        out_end_of_frame;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [8:0]  cfg_data;

  int sender_idle_pct;
  int receiver_stall_pct;
  int cycle_count;
  int bytes_sent;
  int table_writes_sent;
  int mismatch_count;
  int pending_pixels;
  int pixels_checked;
  int frames_closed;

  lcd_pixel_unpack_clut_unit i_dut (.*);

  lcd_pixel_unpack_clut_unit_checker i_checker (.*);

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Random back-pressure on the pixel side
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < receiver_stall_pct);
  end

  // Hard stop on a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("lcd_pixel_unpack_clut_unit verification failed");
      $finish;
    end
  end

  // Drive one input transaction; entered and left at a falling edge
  task automatic send_item(input logic cmd, input logic [7:0] pbyte,
                           input logic [7:0] idx, input logic [11:0] colour);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_cmd = cmd;
    in_pixel_byte = pbyte;
    in_table_index = idx;
    in_table_colour = colour;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    if (cmd == lpu_pkg::CMD_TABLE_WR) table_writes_sent++;
    else bytes_sent++;
  endtask

  task automatic send_byte(input logic [7:0] pbyte);
    send_item(lpu_pkg::CMD_PIXEL_BYTE, pbyte, 8'($urandom), 12'($urandom));
  endtask

  task automatic send_table(input logic [7:0] idx, input logic [11:0] colour);
    send_item(lpu_pkg::CMD_TABLE_WR, 8'($urandom), idx, colour);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [8:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Upper data bits beyond a register's width are junk and must be dropped
  task automatic set_config(input logic [6:0] w, input logic [8:0] h, input logic [2:0] d);
    write_reg(lpu_pkg::CFG_WIDTH_GROUPS, {2'($urandom_range(3)), w});
    write_reg(lpu_pkg::CFG_SCREEN_HEIGHT, h);
    write_reg(lpu_pkg::CFG_DEPTH_SELECT, {6'($urandom_range(63)), d});
  endtask

  // Hold off until every expected pixel is out and the block has gone quiet
  task automatic wait_drained();
    in_valid = 1'b0;
    while (pending_pixels != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    int         counted;
    int         seg_len;
    logic [6:0] w;
    logic [8:0] h;
    logic [2:0] d;
    logic       is_table;

    rst_n = 1'b0;
    in_valid = 1'b0;
    in_cmd = lpu_pkg::CMD_PIXEL_BYTE;
    in_pixel_byte = '0;
    in_table_index = '0;
    in_table_colour = '0;
    cfg_valid = 1'b0;
    cfg_index = lpu_pkg::CFG_WIDTH_GROUPS;
    cfg_data = '0;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: table extremes, every depth, 16 bpp pairing, zero sizes, bad depth
    set_config(7'd1, 9'd2, lpu_pkg::DEPTH_1BPP);
    send_table(8'd0, 12'hABC);
    send_table(8'd255, 12'hFFF);
    send_table(8'd1, 12'h5A3);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hA5);
    wait_drained();
    set_config(7'd1, 9'd2, lpu_pkg::DEPTH_2BPP);
    send_byte(8'h1B);
    send_byte(8'hE4);
    wait_drained();
    set_config(7'd2, 9'd3, lpu_pkg::DEPTH_4BPP);
    send_byte(8'hF0);
    send_byte(8'h0F);
    wait_drained();
    set_config(7'd1, 9'd1, lpu_pkg::DEPTH_8BPP);
    send_byte(8'hFF);
    send_byte(8'h00);
    wait_drained();
    set_config(7'd127, 9'd511, lpu_pkg::DEPTH_16BPP);
    send_byte(8'hFF);
    send_byte(8'hFF);
    send_byte(8'hF8);
    send_byte(8'h1F);
    send_byte(8'h07);
    wait_drained();
    // A bad depth drops the held high byte
    write_reg(lpu_pkg::CFG_DEPTH_SELECT, {6'd0, DEPTH_BAD});
    write_reg(CFG_SPARE, 9'h1FF);
    send_byte(8'h3C);
    wait_drained();
    set_config(7'd0, 9'd4, lpu_pkg::DEPTH_16BPP);
    send_byte(8'h81);
    wait_drained();
    set_config(7'd1, 9'd0, lpu_pkg::DEPTH_1BPP);
    send_byte(8'h7E);
    wait_drained();
    // Small frame picking up the counters left by the wide one
    set_config(7'd1, 9'd1, lpu_pkg::DEPTH_8BPP);
    send_byte(8'h01);
    send_byte(8'hFF);

    // Random segments under four idle/stall mixes
    for (int phase = 0; phase < 4; phase++) begin
      wait_drained();
      case (phase)
        0: begin
          sender_idle_pct = 0;
          receiver_stall_pct = 0;
        end
        1: begin
          sender_idle_pct = 88;
          receiver_stall_pct = 0;
        end
        2: begin
          sender_idle_pct = 0;
          receiver_stall_pct = 88;
        end
        default: begin
          sender_idle_pct = 31;
          receiver_stall_pct = 31;
        end
      endcase
      counted = 0;
      while (counted < RANDOM_ITEMS / 4) begin
        wait_drained();
        w = ($urandom_range(9) == 0) ? ($urandom_range(1) ? 7'd127 : 7'd0)
                                     : 7'($urandom_range(4, 1));
        h = ($urandom_range(9) == 0) ? ($urandom_range(1) ? 9'd511 : 9'd0)
                                     : 9'($urandom_range(6, 1));
        d = ($urandom_range(99) < 85) ? 3'($urandom_range(4)) : 3'($urandom_range(7, 5));
        set_config(w, h, d);
        if ($urandom_range(9) == 0) write_reg(CFG_SPARE, 9'($urandom));
        seg_len = $urandom_range(30, 8);
        if (seg_len > RANDOM_ITEMS / 4 - counted) seg_len = RANDOM_ITEMS / 4 - counted;
        repeat (seg_len) begin
          is_table = ($urandom_range(99) < 15);
          if (is_table) send_table(8'($urandom), 12'($urandom));
          else send_byte(8'($urandom));
          counted++;
        end
      end
    end

    wait_drained();
    $display("stimulus: %0d framebuffer bytes, %0d colour table writes, all depths and mixes",
             bytes_sent, table_writes_sent);
    $display("checked %0d pixels across %0d frame ends, %0d mismatches",
             pixels_checked, frames_closed, mismatch_count);
    if (mismatch_count == 0 && pending_pixels == 0) begin
      $display("lcd_pixel_unpack_clut_unit verification clean");
    end else begin
      $display("lcd_pixel_unpack_clut_unit verification failed");
    end
    $finish;
  end

endmodule
